### sv/et_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// et_pkg: shared definitions for the totient block
// widths and request/response bundles of the bit-serial divider and multiplier
// ----------------------------------------------------------------------------
package et_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } et_div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
    word_t remainder;
  } et_div_rsp_t;

  typedef struct packed {
    logic  start;
    word_t multiplicand;
    word_t multiplier;
  } et_mul_req_t;

  typedef struct packed {
    logic  done;
    word_t product;
  } et_mul_rsp_t;

endpackage

### sv/euler_totient.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_totient: Euler's totient by trial division
// sequencer around a bit-serial divider and a bit-serial multiplier
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_ready carry one value per transaction; out_valid/out_ready
//   carry the matching totient and invalid flag, one result per input
//   a zero value returns totient 0 with invalid set; it passes through
//   S_DONE to the output register, and out_valid rises once that is free
//   otherwise trial factors f = 2, 3, ... are tried while f <= rest / f;
//   each trial is one division in the bit-serial divider, and each factor
//   found adds a shift-add multiply and one more division to look for a
//   repeat; a 32-bit prime takes about 65536 trials, so run time is set
//   by the divider
//   one value is worked on at a time; in_ready is high only while idle
//   the finished result sits in an output register, so a new value is
//   taken while the previous result still waits for out_ready
//   if the receiver stalls with a result pending, the next result holds
//   in the sequencer until the output register frees up
//   reset (rst_n low, synchronous) drops all work in flight and clears
//   out_valid
// ----------------------------------------------------------------------------
module euler_totient (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  et_pkg::word_t       in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output et_pkg::word_t       out_totient,
  output logic                out_invalid
);
  import et_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;  // trial division in flight
  localparam logic [2:0] S_MUL  = 3'd2;  // product update for a found factor
  localparam logic [2:0] S_FMUL = 3'd3;  // final multiply by leftover prime - 1
  localparam logic [2:0] S_DONE = 3'd4;  // result waiting for output register

  logic [2:0] state_r, state_nxt;
  word_t      rest_r, rest_nxt;     // value not yet factored
  word_t      prod_r, prod_nxt;     // running totient
  word_t      f_r, f_nxt;           // current trial factor
  logic       rep_r, rep_nxt;       // factor already divided out once
  logic       inv_r, inv_nxt;

  logic       out_valid_r, out_valid_nxt;
  word_t      out_tot_r, out_tot_nxt;
  logic       out_inv_r, out_inv_nxt;

  et_div_req_t div_req;
  et_div_rsp_t div_rsp;
  et_mul_req_t mul_req;
  et_mul_rsp_t mul_rsp;

  logic in_acc;
  logic out_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;

  always_comb begin
    state_nxt     = state_r;
    rest_nxt      = rest_r;
    prod_nxt      = prod_r;
    f_nxt         = f_r;
    rep_nxt       = rep_r;
    inv_nxt       = inv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_tot_nxt   = out_tot_r;
    out_inv_nxt   = out_inv_r;
    div_req       = '0;
    mul_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rest_nxt = in_value;
          f_nxt    = word_t'(2);
          rep_nxt  = 1'b0;
          if (in_value == '0) begin
            prod_nxt  = '0;
            inv_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            prod_nxt         = word_t'(1);
            inv_nxt          = 1'b0;
            div_req.start    = 1'b1;
            div_req.dividend = in_value;
            div_req.divisor  = word_t'(2);
            state_nxt        = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          if (!rep_r && (f_r > div_rsp.quotient)) begin
            // f squared exceeds what is left: a leftover above one is prime
            if (rest_r > word_t'(1)) begin
              mul_req.start        = 1'b1;
              mul_req.multiplicand = prod_r;
              mul_req.multiplier   = rest_r - word_t'(1);
              state_nxt            = S_FMUL;
            end else begin
              state_nxt = S_DONE;
            end
          end else if (div_rsp.remainder == '0) begin
            // factor divides: first time by f - 1, repeats by f
            rest_nxt             = div_rsp.quotient;
            rep_nxt              = 1'b1;
            mul_req.start        = 1'b1;
            mul_req.multiplicand = prod_r;
            mul_req.multiplier   = rep_r ? f_r : (f_r - word_t'(1));
            state_nxt            = S_MUL;
          end else begin
            // move on to the next trial factor
            f_nxt            = f_r + word_t'(1);
            rep_nxt          = 1'b0;
            div_req.start    = 1'b1;
            div_req.dividend = rest_r;
            div_req.divisor  = f_r + word_t'(1);
          end
        end
      end

      S_MUL: begin
        if (mul_rsp.done) begin
          prod_nxt         = mul_rsp.product;
          div_req.start    = 1'b1;
          div_req.dividend = rest_r;
          div_req.divisor  = f_r;
          state_nxt        = S_DIV;
        end
      end

      S_FMUL: begin
        if (mul_rsp.done) begin
          prod_nxt  = mul_rsp.product;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // hand off once the output register is free or being emptied
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_tot_nxt   = prod_r;
          out_inv_nxt   = inv_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rest_r    <= rest_nxt;
    prod_r    <= prod_nxt;
    f_r       <= f_nxt;
    rep_r     <= rep_nxt;
    inv_r     <= inv_nxt;
    out_tot_r <= out_tot_nxt;
    out_inv_r <= out_inv_nxt;
  end

  et_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  et_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign out_valid   = out_valid_r;
  assign out_totient = out_tot_r;
  assign out_invalid = out_inv_r;

`ifndef SYNTHESIS
  // a flagged result always carries a zero totient
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_inv_r |-> out_tot_r == '0)
    else $error("invalid result with nonzero totient");

  // divider completions only arrive while a division is expected
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider done outside trial division");

  // multiplier completions only arrive while a product update is expected
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == S_MUL || state_r == S_FMUL))
    else $error("multiplier done outside product update");

  // trial factors never drop below two
  a_factor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> f_r >= word_t'(2))
    else $error("trial factor below two");

  // a zero value goes straight to the result
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_value == '0 |=> state_r == S_DONE && inv_r)
    else $error("zero value not flagged");
`endif

endmodule

### sv/et_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// et_div: bit-serial restoring divider
// one quotient bit per cycle, done pulse after
// ----------------------------------------------------------------------------
module et_div (
  input  logic                clk,
  input  logic                rst_n,
  input  et_pkg::et_div_req_t req,
  output et_pkg::et_div_rsp_t rsp
);
  import et_pkg::*;

  word_t            rem_r, rem_nxt;
  word_t            quo_r, quo_nxt;
  word_t            dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             ge;

  always_comb begin
    shifted  = {rem_r, quo_r[WIDTH-1]};
    diff     = shifted - {1'b0, dsr_r};
    ge       = (shifted >= {1'b0, dsr_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      cnt_nxt  = CNT_W'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift one dividend bit into the partial remainder
      rem_nxt = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_nxt = {quo_r[WIDTH-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

### sv/et_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// et_mul: bit-serial shift-add multiplier
// one multiplier bit per cycle, stops once the remaining multiplier bits are 0
// ----------------------------------------------------------------------------
module et_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  et_pkg::et_mul_req_t req,
  output et_pkg::et_mul_rsp_t rsp
);
  import et_pkg::*;

  word_t acc_r, acc_nxt;
  word_t mcand_r, mcand_nxt;
  word_t mplier_r, mplier_nxt;
  logic  busy_r, busy_nxt;
  logic  done_r, done_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      acc_nxt    = '0;
      mcand_nxt  = req.multiplicand;
      mplier_nxt = req.multiplier;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      // product is known to fit the word, so truncation is safe
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = {mcand_r[WIDTH-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[WIDTH-1:1]};
      if (mplier_nxt == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule
